### src/text_console_writer_assert.svh
// Assertion macros shared by the console writer modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the response holds in the next clock cycle.
`define TCW_ASSERT_NEXT(label, trig, resp, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (resp)) else $error(msg);

`endif

### src/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int LAST_ROW_BASE = CELLS - COLUMNS;

  // Field widths.
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int INDEX_W = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic exec;
    logic copy;
    logic blank;
    logic ptr_clear;
    logic ptr_row;
    logic ptr_inc;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    need_scroll;
    logic    ptr_copy_end;
    logic    ptr_end;
  } tcw_status_t;

endpackage

`default_nettype wire

### src/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/tcw_ctrl.sv
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  output tcw_cmd_t         cmd,
  input  wire tcw_status_t status
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    COPY,
    BLANK
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  always_comb begin
    state_next = state;
    finish = 1'b0;
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.idle = 1'b1;
        if (start) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        cmd.exec = 1'b1;
        case (status.op)
          OP_PUT: begin
            if (status.need_scroll) begin
              cmd.ptr_clear = 1'b1;
              state_next = COPY;
            end else begin
              finish = 1'b1;
              state_next = IDLE;
            end
          end
          OP_CLEAR: begin
            cmd.ptr_clear = 1'b1;
            state_next = BLANK;
          end
          default: begin
            finish = 1'b1;
            state_next = IDLE;
          end
        endcase
      end
      COPY: begin
        cmd.copy = 1'b1;
        if (status.ptr_copy_end) begin
          cmd.ptr_row = 1'b1;
          state_next = BLANK;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      BLANK: begin
        cmd.blank = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.ptr_end) begin
          finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= finish;
    end
  end

  assign busy = (state != IDLE);

  // A result strobe is a single pulse: no item can finish straight after another.
  `TCW_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")
  // Reads and no-op items finish right after their execute cycle.
  `TCW_ASSERT_NEXT(a_short_item, state == EXEC && (status.op == OP_READ || status.op == OP_NONE), done && state == IDLE, "short item did not finish")
  // The row copy always hands over to blanking of the bottom row.
  `TCW_ASSERT_NEXT(a_copy_to_blank, state == COPY && status.ptr_copy_end, state == BLANK && !done, "scroll copy did not move to blanking")

endmodule

`default_nettype wire

### src/tcw_dp.sv
`default_nettype none
`include "text_console_writer_assert.svh"

module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcw_cmd_t           cmd,
  output tcw_status_t             status,
  input  wire logic [1:0]         opcode,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic [INDEX_W-1:0] cell_index,
  input  wire logic               cfg_write,
  input  wire logic [ATTR_W-1:0]  cfg_data,
  output logic      [COL_W-1:0]   cursor_col,
  output logic      [ROW_W-1:0]   cursor_row,
  output logic      [ADDR_W-1:0]  cursor_pos,
  output logic                    scrolled,
  output logic      [CHAR_W-1:0]  read_char,
  output logic      [ATTR_W-1:0]  read_attr
);

  logic [ATTR_W-1:0] attribute;
  opcode_t           op;
  logic [CHAR_W-1:0] char_val;
  logic              index_ok;
  logic [ADDR_W-1:0] ptr;

  logic              index_ok_in;
  logic [COL_W:0]    col_inc;
  logic              is_newline;
  logic              wrap;
  logic              last_row;
  logic              need_scroll;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign index_ok_in = (32'(cell_index) < CELLS);
  assign col_inc = {1'b0, cursor_col} + 1'b1;
  assign is_newline = (char_val == NEWLINE_CODE);
  assign wrap = is_newline || (col_inc == (COL_W + 1)'(COLUMNS));
  assign last_row = (cursor_row == ROW_W'(ROWS - 1));
  assign need_scroll = (op == OP_PUT) && wrap && last_row;

  assign status.op = op;
  assign status.need_scroll = need_scroll;
  assign status.ptr_copy_end = (ptr == ADDR_W'(LAST_ROW_BASE));
  assign status.ptr_end = (ptr == ADDR_W'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_write) begin
      attribute <= cfg_data;
    end
  end

  // Item fields are sampled every idle cycle; the one taken with start is used.
  always_ff @(posedge clk) begin
    if (cmd.idle) begin
      op <= opcode_t'(opcode);
      char_val <= char_code;
      index_ok <= index_ok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.ptr_clear) begin
      ptr <= '0;
    end else if (cmd.ptr_row) begin
      ptr <= ADDR_W'(LAST_ROW_BASE);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      cursor_pos <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_PUT: begin
          if (wrap) begin
            cursor_col <= '0;
            if (last_row) begin
              cursor_pos <= ADDR_W'(LAST_ROW_BASE);
            end else begin
              cursor_row <= cursor_row + 1'b1;
              cursor_pos <= cursor_pos + (ADDR_W'(COLUMNS) - ADDR_W'(cursor_col));
            end
          end else begin
            cursor_col <= col_inc[COL_W-1:0];
            cursor_pos <= cursor_pos + 1'b1;
          end
        end
        OP_CLEAR: begin
          cursor_col <= '0;
          cursor_row <= '0;
          cursor_pos <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scrolled <= need_scroll;
      if (op == OP_READ && index_ok) begin
        read_char <= ram_rdata[CELL_W-1:ATTR_W];
        read_attr <= ram_rdata[ATTR_W-1:0];
      end else begin
        read_char <= '0;
        read_attr <= '0;
      end
    end
  end

  // Write port: character put, scroll copy of each cell one row up, or blanking.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cursor_pos;
    ram_wdata = {char_val, attribute};
    if (cmd.exec && op == OP_PUT && !is_newline) begin
      ram_we = 1'b1;
    end else if (cmd.copy && ptr != '0) begin
      ram_we = 1'b1;
      ram_waddr = ptr - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.blank) begin
      ram_we = 1'b1;
      ram_waddr = ptr;
      ram_wdata = {BLANK_CODE, attribute};
    end
  end

  // Read port: the addressed cell while idle, the next row's cell while copying.
  always_comb begin
    if (cmd.idle) begin
      ram_re = index_ok_in;
      ram_raddr = ADDR_W'(cell_index);
    end else begin
      ram_re = cmd.copy && !status.ptr_copy_end;
      ram_raddr = ptr + ADDR_W'(COLUMNS);
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `TCW_ASSERT_ALWAYS(a_col_range, 32'(cursor_col) < COLUMNS, "cursor column beyond the screen")
  `TCW_ASSERT_ALWAYS(a_row_range, 32'(cursor_row) < ROWS, "cursor row beyond the screen")
  `TCW_ASSERT_ALWAYS(a_pos_range, 32'(cursor_pos) < CELLS, "cursor position beyond the last cell")

endmodule

`default_nettype wire

### src/text_console_writer.sv
// Text console writer: an 80 by 25 character screen held in on-chip memory.
// An item is accepted on a rising edge where start is high and busy is low.
// opcode selects put (char_code at the cursor, code 10 is a newline), clear
// (blank every cell and home the cursor) or read (return cell cell_index).
// One result beat follows each item: done is high for exactly one cycle and
// the cursor, scrolled and read fields are valid in that cycle. The receiver
// cannot stall; it must take the beat when done is high.
// A put, a read or an unused opcode passes through the execute state to the
// done beat, and the next item may be accepted in the cycle done is shown.
// A put that scrolls walks the single write port of the cell memory,
// first moving the rows up and then blanking the bottom row. A clear
// writes all 2000 cells. busy stays high throughout.
// The attribute register is written through cfg_write and cfg_data; the
// user must do so only while the block is idle, which the block itself
// does not enforce. It resets to 0x0f. Reset homes the cursor and leaves
// the cell memory undefined until it is cleared or written.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic [INDEX_W-1:0] cell_index,
  input  wire logic               cfg_write,
  input  wire logic [ATTR_W-1:0]  cfg_data,
  output logic                    done,
  output logic      [COL_W-1:0]   cursor_col,
  output logic      [ROW_W-1:0]   cursor_row,
  output logic      [ADDR_W-1:0]  cursor_pos,
  output logic                    scrolled,
  output logic      [CHAR_W-1:0]  read_char,
  output logic      [ATTR_W-1:0]  read_attr
);

  // The controller sequences each item; the datapath owns the cursor,
  // the attribute register, the sweep pointer and the cell memory.
  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .status(status)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .opcode    (opcode),
    .char_code (char_code),
    .cell_index(cell_index),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cursor_pos(cursor_pos),
    .scrolled  (scrolled),
    .read_char (read_char),
    .read_attr (read_attr)
  );

endmodule

`default_nettype wire
